@@ sv/bpid_pkg.sv @@
`default_nettype none

package bpid_pkg;

    // Spacing counter width and the derived widths of the period arithmetic.
    localparam int SPACING_BITS = 16;
    localparam int REF_W        = SPACING_BITS + 1;
    localparam int THR_W        = 15;
    localparam int TOL_W        = 7;
    localparam int PROD_W       = TOL_W + REF_W;
    localparam int SCALE_W      = REF_W + 9;
    localparam int SAMPLE_W     = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE        = CFG_IDX_W'(1);

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(5000);
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(60);

    // Spacing count at which two spacings have been skipped and the third is due.
    localparam logic [1:0] SEEN_SKIP = 2'd2;
    localparam logic [1:0] SEEN_FULL = 2'd3;

    typedef struct packed {
        logic bit_valid;
        logic bit_value;
        logic capture_end;
        logic no_bits_error;
    } result_t;

endpackage

`default_nettype wire

@@ sv/biphase_peak_interval_decoder_unit.sv @@
// Each result is written to the output register or skid entry as its sample is accepted.
// One sample per cycle unless stalled; all per-sample work sits between state registers.
// A one-cycle input stall follows each tolerance write while the tolerance product reloads.
// A two-entry output buffer lets result-less samples keep flowing while a result waits.
// Reset (rst_n, asynchronous, active low) clears all decoder state and restores the
// registers to threshold 5000 and tolerance 60 percent.
`default_nettype none

module biphase_peak_interval_decoder_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Sample channel.
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic signed [bpid_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                            last_sample,
    // Result channel.
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 bit_valid,
    output logic                                 bit_value,
    output logic                                 capture_end,
    output logic                                 no_bits_error,
    // Configuration write channel.
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bpid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bpid_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bpid_pkg::*;

    localparam logic [SPACING_BITS-1:0] CNT_MAX = '1;

    // The acceptance windows compare |v - c| < floor(x / k) where x is
    // tolerance times reference. For integers this equals k * (|v - c| + 1) <= x,
    // so no divider is needed: k is 100 for the full window and 200 for the half.
    function automatic logic in_win(
        input logic [REF_W-1:0]  v,
        input logic [REF_W-1:0]  c,
        input logic [PROD_W-1:0] x,
        input logic              half
    );
        logic [REF_W-1:0]   delta;
        logic [SCALE_W-1:0] d1;
        logic [SCALE_W-1:0] scaled;
        delta  = (v >= c) ? (v - c) : (c - v);
        d1     = SCALE_W'(delta) + SCALE_W'(1);
        scaled = (d1 << 6) + (d1 << 5) + (d1 << 2);
        if (half)
        begin
            scaled = scaled << 1;
        end
        in_win = (scaled <= SCALE_W'(x));
    endfunction

    // Configuration registers.
    logic [THR_W-1:0] thr_reg;
    logic [TOL_W-1:0] tol_reg;
    logic             refresh_reg;
    logic             cfg_fire;

    // Decoder state.
    logic [SPACING_BITS-1:0] cnt_reg,      cnt_next;
    logic                    in_pulse_reg, in_pulse_next;
    logic [THR_W-1:0]        pmax_reg,     pmax_next;
    logic [SPACING_BITS-1:0] cand_reg,     cand_next;
    logic [1:0]              seen_reg,     seen_next;
    logic [SPACING_BITS-1:0] pend_reg,     pend_next;
    logic                    pv_reg,       pv_next;
    logic [REF_W-1:0]        ref_reg,      ref_next;
    // Tolerance times reference, kept in step with ref_reg.
    logic [PROD_W-1:0]       x_reg,        x_next;

    // Output buffer.
    result_t out_reg, skid_reg, res;
    logic    out_valid_reg, skid_valid_reg;

    logic                    in_fire;
    logic                    res_new;
    logic                    out_take;
    logic [SAMPLE_W-1:0]     raw;
    logic [SAMPLE_W-1:0]     mag;
    logic [THR_W-1:0]        level;
    logic                    above;
    logic                    upd;
    logic                    commit;
    logic [SPACING_BITS-1:0] s;
    logic [SPACING_BITS-1:0] cnt_after;
    logic                    p_half;
    logic                    s_half;
    logic                    p_full;
    logic [REF_W-1:0]        half_ref;
    logic [REF_W-1:0]        mul_a;
    logic [PROD_W-1:0]       prod_a;
    logic [PROD_W-1:0]       prod_p;
    logic                    got_bit;
    logic                    bit_val;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // A waiting skid entry means both output slots may be full. The cycle after a
    // tolerance write is spent reloading the tolerance product.
    assign in_stall = skid_valid_reg || refresh_reg;
    assign in_fire  = in_valid && !in_stall;

    // Magnitude of the sample; the most negative code saturates to full scale.
    assign raw   = sample;
    assign mag   = raw[SAMPLE_W-1] ? SAMPLE_W'(~raw + SAMPLE_W'(1)) : raw;
    assign level = mag[SAMPLE_W-1] ? '1 : mag[THR_W-1:0];
    assign above = level > thr_reg;

    // Peak tracking: the first sample holding the run's maximum sets the candidate.
    assign upd = above && (!in_pulse_reg || (level > pmax_reg));
    assign s   = upd ? cnt_reg : cand_reg;

    // A pulse closes on its first sample below threshold, or when the capture
    // ends while a pulse is open.
    assign commit = (in_pulse_reg && !above) || ((in_pulse_reg || above) && last_sample);

    assign half_ref = ref_reg >> 1;
    assign p_half   = in_win(REF_W'(pend_reg), half_ref, x_reg, 1'b1);
    assign s_half   = in_win(REF_W'(s),        half_ref, x_reg, 1'b1);
    assign p_full   = in_win(REF_W'(pend_reg), ref_reg,  x_reg, 1'b0);

    // Products for every value the reference can take next. A new reference
    // from the third spacing comes from cand_reg, since a pulse that closes
    // before the last sample cannot update its candidate in the same cycle.
    assign mul_a  = refresh_reg ? ref_reg : REF_W'(cand_reg);
    assign prod_a = PROD_W'(tol_reg) * PROD_W'(mul_a);
    assign prod_p = PROD_W'(tol_reg) * PROD_W'(pend_reg);

    always_comb
    begin
        cnt_next      = cnt_reg;
        in_pulse_next = in_pulse_reg;
        pmax_next     = pmax_reg;
        cand_next     = cand_reg;
        seen_next     = seen_reg;
        pend_next     = pend_reg;
        pv_next       = pv_reg;
        ref_next      = ref_reg;
        x_next        = x_reg;
        got_bit       = 1'b0;
        bit_val       = 1'b0;
        cnt_after     = cnt_reg;
        res           = '0;

        if (refresh_reg)
        begin
            x_next = prod_a;
        end

        if (in_fire)
        begin
            if (upd)
            begin
                pmax_next = level;
                cand_next = cnt_reg;
            end
            if (above)
            begin
                in_pulse_next = 1'b1;
            end

            if (commit)
            begin
                cnt_after     = cnt_reg - s;
                in_pulse_next = 1'b0;
                pmax_next     = '0;
                cand_next     = '0;
                // A zero spacing only arises from a peak on the very first sample.
                if (s != '0)
                begin
                    if (seen_reg < SEEN_SKIP)
                    begin
                        seen_next = seen_reg + 2'd1;
                    end
                    else if (!pv_reg)
                    begin
                        if (seen_reg == SEEN_SKIP)
                        begin
                            ref_next = REF_W'(s);
                            x_next   = prod_a;
                        end
                        seen_next = SEEN_FULL;
                        pend_next = s;
                        pv_next   = 1'b1;
                    end
                    else
                    begin
                        seen_next = SEEN_FULL;
                        if (p_half)
                        begin
                            if (s_half)
                            begin
                                // Two half periods: a one.
                                ref_next  = {pend_reg, 1'b0};
                                x_next    = prod_p << 1;
                                pv_next   = 1'b0;
                                pend_next = '0;
                                got_bit   = 1'b1;
                                bit_val   = 1'b1;
                            end
                            else
                            begin
                                pend_next = s;
                            end
                        end
                        else if (p_full)
                        begin
                            // One full period: a zero.
                            ref_next  = REF_W'(pend_reg);
                            x_next    = prod_p;
                            pend_next = s;
                            got_bit   = 1'b1;
                        end
                        else
                        begin
                            pend_next = s;
                        end
                    end
                end
            end

            cnt_next = (cnt_after != CNT_MAX) ? cnt_after + SPACING_BITS'(1) : cnt_after;

            res.bit_valid     = got_bit;
            res.bit_value     = got_bit && bit_val;
            res.capture_end   = last_sample;
            res.no_bits_error = last_sample && (seen_next < SEEN_FULL);

            // The capture is over: every state element starts afresh.
            if (last_sample)
            begin
                cnt_next      = '0;
                in_pulse_next = 1'b0;
                pmax_next     = '0;
                cand_next     = '0;
                seen_next     = '0;
                pend_next     = '0;
                pv_next       = 1'b0;
                ref_next      = '0;
                x_next        = '0;
            end
        end
    end

    assign res_new  = in_fire && (got_bit || last_sample);
    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= THR_RESET;
            tol_reg     <= TOL_RESET;
            refresh_reg <= 1'b0;
        end
        else
        begin
            refresh_reg <= cfg_fire && (cfg_index == CFG_TOLERANCE);
            if (cfg_fire)
            begin
                case (cfg_index)
                    CFG_DETECT_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                    CFG_TOLERANCE:        tol_reg <= cfg_data[TOL_W-1:0];
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            in_pulse_reg <= 1'b0;
            pmax_reg     <= '0;
            cand_reg     <= '0;
            seen_reg     <= '0;
            pend_reg     <= '0;
            pv_reg       <= 1'b0;
            ref_reg      <= '0;
            x_reg        <= '0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            in_pulse_reg <= in_pulse_next;
            pmax_reg     <= pmax_next;
            cand_reg     <= cand_next;
            seen_reg     <= seen_next;
            pend_reg     <= pend_next;
            pv_reg       <= pv_next;
            ref_reg      <= ref_next;
            x_reg        <= x_next;
        end
    end

    // Output register with a skid entry behind it. New requests go to the skid
    // entry only when the output register is full and not being taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (res_new)
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (res_new)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign bit_valid     = out_reg.bit_valid;
    assign bit_value     = out_reg.bit_value;
    assign capture_end   = out_reg.capture_end;
    assign no_bits_error = out_reg.no_bits_error;

    // The skid entry is only ever filled behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a request while the output register is empty");

    // The tolerance product tracks the reference except right after a tolerance write.
    a_prod_tracks_ref: assert property (@(posedge clk) disable iff (!rst_n)
        !refresh_reg |-> (x_reg == PROD_W'(tol_reg) * PROD_W'(ref_reg)))
        else $error("tolerance product out of step with reference period");

    // A pending spacing only exists once the reference period has been set.
    a_pending_after_ref: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> (seen_reg == SEEN_FULL))
        else $error("pending spacing before reference period was set");

    // The last sample of a capture leaves the decoder cleared.
    a_capture_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last_sample) |=> (seen_reg == '0 && !pv_reg && !in_pulse_reg
                                      && ref_reg == '0))
        else $error("decoder state not cleared after capture end");

endmodule

`default_nettype wire

@@ sim/tb_biphase_peak_interval_decoder_unit.sv @@
module tb_biphase_peak_interval_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bpid_pkg::*;

    // The register map has two entries. Index 3 is unused, and a write to it must change
    // nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

    // Tolerance is a percentage of the bit period.
    localparam longint PERCENT = 100;

    // The spacing counter stops at all ones, so very long gaps read as this value.
    localparam logic [SPACING_BITS-1:0] GAP_SAT = '1;

    // These are the reports that can be read straight off the decoder's behavior.
    localparam result_t NO_REPORT   = '0;
    localparam result_t END_NO_BITS = '{bit_valid: 1'b0, bit_value: 1'b0,
                                        capture_end: 1'b1, no_bits_error: 1'b1};

    typedef struct {
        logic signed [SAMPLE_W-1:0] smp;
        logic                       lst;
        bit                         typed;
        result_t                    rpt;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
    logic                       out_valid;
    logic                       out_stall;
    logic                       bit_valid;
    logic                       bit_value;
    logic                       capture_end;
    logic                       no_bits_error;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    // A sample request can carry a report typed in by hand. When it does, that report
    // stands in for the one the decoder copy below works out.
    bit      row_typed;
    result_t row_rpt;

    // This is the testbench's own copy of the decoder: its registers and its state.
    logic [THR_W-1:0]        cur_threshold;
    logic [TOL_W-1:0]        cur_tolerance;
    logic [SPACING_BITS-1:0] since_peak;
    bit                      in_run;
    logic [THR_W-1:0]        run_peak;
    logic [SPACING_BITS-1:0] cand_gap;
    logic [1:0]              gaps_seen;
    logic [SPACING_BITS-1:0] held_gap;
    bit                      held_ok;
    logic [REF_W-1:0]        bit_period;

    // This holds the decoder reports that are still owed by the block, oldest first.
    result_t pending_reports[$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int idle_pct       = 0;
    int stall_pct      = 0;

    // The swipe generator shapes its pulses around the threshold that it has just
    // programmed.
    logic [THR_W-1:0]           gen_threshold;
    logic signed [SAMPLE_W-1:0] swipe_samples[$];
    stim_row_t                  directed_rows[20];

    biphase_peak_interval_decoder_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .last_sample   (last_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .bit_valid     (bit_valid),
        .bit_value     (bit_value),
        .capture_end   (capture_end),
        .no_bits_error (no_bits_error),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // The decoder copy
    // ------------------------------------------------------------------------

    function automatic void clear_decoder();
        since_peak = '0;
        in_run     = 1'b0;
        run_peak   = '0;
        cand_gap   = '0;
        gaps_seen  = '0;
        held_gap   = '0;
        held_ok    = 1'b0;
        bit_period = '0;
    endfunction

    // Both bounds are open. A window whose lower edge falls below zero therefore
    // accepts every small spacing.
    function automatic bit in_window(input longint v, input longint centre, input longint half);
        return (v < centre + half) && (v > centre - half);
    endfunction

    // One spacing goes in. The first two only count. The third sets the bit period and
    // waits. Each later spacing acts as lookahead for the one that is held, or is held itself when none is.
    function automatic bit take_gap(input logic [SPACING_BITS-1:0] s, output bit bval);
        longint span;
        longint full_tol;
        longint half_tol;
        longint half_span;
        longint p;
        bval = 1'b0;
        if (gaps_seen < SEEN_SKIP)
        begin
            gaps_seen++;
            return 1'b0;
        end
        if (!held_ok)
        begin
            if (gaps_seen == SEEN_SKIP)
                bit_period = REF_W'(s);
            gaps_seen = SEEN_FULL;
            held_gap  = s;
            held_ok   = 1'b1;
            return 1'b0;
        end
        gaps_seen = SEEN_FULL;
        span      = longint'(bit_period);
        full_tol  = (longint'(cur_tolerance) * span) / PERCENT;
        half_tol  = full_tol / 2;
        half_span = span / 2;
        p         = longint'(held_gap);
        if (in_window(p, half_span, half_tol))
        begin
            // A held half period decodes as a one only when the lookahead is another
            // half period.
            if (in_window(longint'(s), half_span, half_tol))
            begin
                bit_period = {held_gap, 1'b0};
                held_ok    = 1'b0;
                held_gap   = '0;
                bval       = 1'b1;
                return 1'b1;
            end
            held_gap = s;
            return 1'b0;
        end
        if (in_window(p, span, full_tol))
        begin
            bit_period = REF_W'(held_gap);
            held_gap   = s;
            return 1'b1;
        end
        held_gap = s;
        return 1'b0;
    endfunction

    // This advances the decoder copy by one sample. It returns 1 when the sample owes
    // a report.
    function automatic bit f2f_decode_step(input logic signed [SAMPLE_W-1:0] smp,
                                           input logic lst, output result_t rpt);
        int                      lvl;
        logic [SPACING_BITS-1:0] d;
        logic [SPACING_BITS-1:0] s;
        bit                      above;
        bit                      was_in;
        bit                      commit;
        bit                      got;
        bit                      bval;
        rpt    = NO_REPORT;
        got    = 1'b0;
        bval   = 1'b0;
        d      = since_peak;
        was_in = in_run;
        // The magnitude saturates, so the most negative sample reads as full scale.
        lvl = (smp < 0) ? -int'(smp) : int'(smp);
        if (lvl > 32767)
            lvl = 32767;
        above = lvl > int'(cur_threshold);
        if (above)
        begin
            // Only a strictly larger level moves the peak, so the first maximum in a
            // run wins.
            if (!in_run || lvl > int'(run_peak))
            begin
                run_peak = THR_W'(lvl);
                cand_gap = d;
            end
            in_run = 1'b1;
        end
        // A run that is still open at the last sample ends there.
        commit = (was_in && !above) || (in_run && lst);
        if (commit)
        begin
            s          = cand_gap;
            since_peak = d - s;
            in_run     = 1'b0;
            run_peak   = '0;
            cand_gap   = '0;
            // A zero spacing comes only from a peak on the first sample, and it does
            // not count.
            if (s != '0)
                got = take_gap(s, bval);
        end
        if (since_peak != GAP_SAT)
            since_peak++;
        rpt.bit_valid = got;
        rpt.bit_value = got & bval;
        if (lst)
        begin
            // At capture end the held spacing has no lookahead and is dropped.
            rpt.capture_end   = 1'b1;
            rpt.no_bits_error = gaps_seen < SEEN_FULL;
            clear_decoder();
            return 1'b1;
        end
        return got;
    endfunction

    // ------------------------------------------------------------------------
    // Checking. Requests are sampled at the clock edge and so see the values from
    // before the edge.
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin : report_check
        bit      has;
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            // The decoder copy starts from the reset registers and a clear state.
            cur_threshold = THR_RESET;
            cur_tolerance = TOL_RESET;
            clear_decoder();
            pending_reports.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DETECT_THRESHOLD: cur_threshold = cfg_data[THR_W-1:0];
                    CFG_TOLERANCE:        cur_tolerance = cfg_data[TOL_W-1:0];
                    default:              ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                has = f2f_decode_step(sample, last_sample, want);
                if (row_typed)
                begin
                    has  = 1'b1;
                    want = row_rpt;
                end
                if (has)
                    pending_reports = {pending_reports, want};
            end
            if (out_valid && !out_stall)
            begin
                got = '{bit_valid, bit_value, capture_end, no_bits_error};
                if (pending_reports.size() == 0)
                begin
                    $error("unexpected report %b with none outstanding", got);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (got.bit_valid !== want.bit_valid)
                    begin
                        $error("bit_valid: expected %0d, actual %0d", want.bit_valid,
                               got.bit_valid);
                        mismatch_count++;
                    end
                    if (got.bit_value !== want.bit_value)
                    begin
                        $error("bit_value: expected %0d, actual %0d", want.bit_value,
                               got.bit_value);
                        mismatch_count++;
                    end
                    if (got.capture_end !== want.capture_end)
                    begin
                        $error("capture_end: expected %0d, actual %0d", want.capture_end,
                               got.capture_end);
                        mismatch_count++;
                    end
                    if (got.no_bits_error !== want.no_bits_error)
                    begin
                        $error("no_bits_error: expected %0d, actual %0d", want.no_bits_error,
                               got.no_bits_error);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // The receiver stalls at random, and each clock edge gets a fresh draw.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // This drives one sample request and returns at the edge that accepts it. Valid
    // stays high after that edge, so a request that follows at once keeps the channel
    // busy.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic lst,
                               input bit typed = 1'b0, input result_t rpt = NO_REPORT);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample      <= smp;
        last_sample <= lst;
        row_typed   <= typed;
        row_rpt     <= rpt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // This lowers valid and waits until every owed report has arrived. The first edge
    // lets the checker log the report of a request accepted just before. A few more
    // edges follow, because a sample that owes no report may still be in flight.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // The writes go back to back. The tolerance write carries random upper data bits,
    // which the block must mask off.
    task automatic write_config(input logic [THR_W-1:0] thr, input logic [TOL_W-1:0] tol,
                                input bit spare);
        logic [CFG_IDX_W-1:0]  idx[3];
        logic [CFG_DATA_W-1:0] dat[3];
        int                    n;
        idx[0] = CFG_DETECT_THRESHOLD;
        dat[0] = CFG_DATA_W'(thr);
        idx[1] = CFG_TOLERANCE;
        dat[1] = {8'($urandom), tol};
        idx[2] = CFG_SPARE;
        dat[2] = CFG_DATA_W'($urandom);
        n = spare ? 3 : 2;
        for (int k = 0; k < n; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= dat[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // This appends one sample to the swipe being built.
    function automatic void add_sample(input logic signed [SAMPLE_W-1:0] smp);
        swipe_samples = {swipe_samples, smp};
    endfunction

    // A background sample never rises above the threshold.
    function automatic logic signed [SAMPLE_W-1:0] quiet_level();
        int mag;
        mag = int'($urandom_range(int'(gen_threshold)));
        return SAMPLE_W'(($urandom_range(1) == 1) ? -mag : mag);
    endfunction

    // A pulse sample rises above the threshold. At the top threshold no pulse can form,
    // so the sample is just random.
    function automatic logic signed [SAMPLE_W-1:0] pulse_level(input bit neg);
        int mag;
        if (gen_threshold == '1)
            return SAMPLE_W'($urandom);
        mag = int'($urandom_range(32767, int'(gen_threshold) + 1));
        if (neg && mag == 32767 && $urandom_range(1) == 1)
            return 16'sh8000;
        return SAMPLE_W'(neg ? -mag : mag);
    endfunction

    // This appends a pulse one to three samples wide, then background up to the given
    // spacing. Where the peak falls inside the pulse adds a little jitter to the
    // spacing.
    function automatic void add_pulse(input int gap, input bit neg);
        int width;
        width = int'($urandom_range(1, 3));
        if (width >= gap)
            width = 1;
        repeat (width) add_sample(pulse_level(neg));
        repeat (gap - width) add_sample(quiet_level());
    endfunction

    function automatic int jitter(input int gap);
        return gap + int'($urandom_range(2)) - 1;
    endfunction

    task automatic send_swipe();
        foreach (swipe_samples[i])
            send_sample(swipe_samples[i], i == swipe_samples.size() - 1);
    endtask

    // Most captures are well formed: background, clocking zeros, then random bits, with
    // now and then a stray spacing. The rest are pure noise. A capture may end inside a
    // pulse or in background.
    task automatic send_capture();
        int period;
        bit neg;
        swipe_samples.delete();
        if ($urandom_range(5) == 0)
        begin
            repeat ($urandom_range(1, 24)) add_sample(SAMPLE_W'($urandom));
        end
        else
        begin
            period = ($urandom_range(7) == 0) ? int'($urandom_range(21, 28))
                                              : int'($urandom_range(8, 12));
            neg    = 1'($urandom_range(1));
            repeat ($urandom_range(5)) add_sample(quiet_level());
            repeat ($urandom_range(1, 3))
            begin
                add_pulse(jitter(period), neg);
                neg = !neg;
            end
            repeat ($urandom_range(3))
            begin
                case ($urandom_range(9))
                    0:
                        add_pulse(int'($urandom_range(2, 2 * period)), neg);
                    1, 2, 3, 4:
                    begin
                        add_pulse(jitter(period / 2), neg);
                        neg = !neg;
                        add_pulse(jitter(period / 2), neg);
                    end
                    default:
                        add_pulse(jitter(period), neg);
                endcase
                neg = !neg;
            end
            add_pulse(jitter(period), neg);
            add_sample(($urandom_range(1) == 1) ? pulse_level(!neg) : quiet_level());
        end
        send_swipe();
    endtask

    initial
    begin : stimulus
        logic [THR_W-1:0] thr_plan[8];
        logic [TOL_W-1:0] tol_plan[8];
        int               phase_start;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        sample      <= '0;
        last_sample <= 1'b0;
        row_typed   <= 1'b0;
        row_rpt     <= NO_REPORT;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        gen_threshold = THR_RESET;

        // The directed swipe runs with the reset registers. The first two captures end
        // with no spacing at all: an empty capture, and a lone full-scale negative
        // sample whose peak sits on the first sample. The next capture has peaks at
        // spacings of 4, 4 and 4, which set the period, then 2 and 2. It touches both
        // sides of the threshold and both ends of the sample range. It decodes a zero,
        // and then a one that travels in the capture-end report.
        directed_rows = '{
            '{16'sd0,      1'b1, 1'b1, END_NO_BITS},
            '{16'sh8000,   1'b1, 1'b1, END_NO_BITS},
            '{-16'sd1,     1'b0, 1'b0, NO_REPORT},
            '{16'sd5000,   1'b0, 1'b0, NO_REPORT},
            '{-16'sd5000,  1'b0, 1'b0, NO_REPORT},
            '{16'sd1,      1'b0, 1'b0, NO_REPORT},
            '{16'sd32767,  1'b0, 1'b0, NO_REPORT},
            '{16'sd0,      1'b0, 1'b0, NO_REPORT},
            '{16'sd100,    1'b0, 1'b0, NO_REPORT},
            '{-16'sd200,   1'b0, 1'b0, NO_REPORT},
            '{16'sh8000,   1'b0, 1'b0, NO_REPORT},
            '{16'sd0,      1'b0, 1'b0, NO_REPORT},
            '{16'sd0,      1'b0, 1'b0, NO_REPORT},
            '{16'sd0,      1'b0, 1'b0, NO_REPORT},
            '{16'sd5001,   1'b0, 1'b0, NO_REPORT},
            '{16'sd4999,   1'b0, 1'b0, NO_REPORT},
            '{-16'sd20000, 1'b0, 1'b0, NO_REPORT},
            '{16'sd0,      1'b0, 1'b0, NO_REPORT},
            '{16'sd12345,  1'b0, 1'b0, NO_REPORT},
            '{16'sd0,      1'b1, 1'b0, NO_REPORT}
        };

        // The register plan for each phase. It covers the reset values, both
        // threshold extremes, zero tolerance, and a tolerance above 100 percent, which
        // lets windows reach below zero.
        thr_plan[0] = THR_RESET;
        tol_plan[0] = TOL_RESET;
        thr_plan[1] = '0;
        tol_plan[1] = '0;
        thr_plan[2] = '1;
        tol_plan[2] = TOL_W'(100);
        thr_plan[3] = THR_W'(1000);
        tol_plan[3] = TOL_W'(100);
        thr_plan[4] = THR_W'($urandom_range(300, 12000));
        tol_plan[4] = TOL_W'($urandom_range(20, 99));
        thr_plan[5] = THR_W'(2000);
        tol_plan[5] = '1;
        thr_plan[6] = THR_W'($urandom_range(300, 20000));
        tol_plan[6] = TOL_W'($urandom_range(20, 127));
        thr_plan[7] = THR_W'($urandom_range(300, 12000));
        tol_plan[7] = TOL_W'(60);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            send_sample(directed_rows[k].smp, directed_rows[k].lst, directed_rows[k].typed,
                        directed_rows[k].rpt);

        for (int ph = 0; ph < 8; ph++)
        begin
            // The idling modes rotate: none, sender idle, receiver stalling, and both.
            case (ph % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 54; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            if (ph > 0)
            begin
                wait_drained();
                write_config(thr_plan[ph], tol_plan[ph], ph == 3);
                gen_threshold = thr_plan[ph];
            end
            phase_start = items_sent;
            while (items_sent - phase_start < 24)
                send_capture();
        end

        stall_pct = 0;
        wait_drained();
        if (pending_reports.size() != 0)
            $error("%0d reports never arrived", pending_reports.size());
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // This is the run limit. The slowest correct run takes well under a tenth of it.
    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
